/* hdl/bba_pkg.sv */
// Shared types, constants and codes for the bitmap block allocator.
// Depends on nothing; every other file of the block but bba_map_ram imports it.

package bba_pkg;

  // Bitmap geometry. WORD_BITS must be a power of two.
  localparam int MAP_BITS  = 4096;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W   = $clog2(MAP_BITS);
  localparam int NW      = $clog2(MAP_BITS + 1);

  localparam int ID_W     = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [ID_W-1:0] BASE_RESET = 16'd0;
  localparam logic [ID_W-1:0] END_RESET  = 16'd4096;

  // Request operations.
  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_MARK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_TEST  = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BASE = 1'b0,
    REG_END  = 1'b1
  } reg_idx_e;

  // Configuration values seen by the controller.
  typedef struct packed {
    logic [ID_W-1:0] base_block;
    logic [ID_W-1:0] block_end;
  } cfg_t;

endpackage

/* hdl/bba_map_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and only updates when a read is enabled.

module bba_map_ram #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bba_regs.sv */
// APB-style configuration registers for the allocator window.
// Depends on bba_pkg for the register indexes and the cfg_t struct.

module bba_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::PADDR_W-1:0] paddr,
  input  logic [bba_pkg::PDATA_W-1:0] pwdata,
  output logic [bba_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output bba_pkg::cfg_t               cfg
);
  import bba_pkg::*;

  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_block <= BASE_RESET;
      cfg.block_end  <= END_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE: cfg.base_block <= pwdata[ID_W-1:0];
        REG_END:  cfg.block_end  <= pwdata[ID_W-1:0];
        default:  ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_BASE: prdata = PDATA_W'(cfg.base_block);
      REG_END:  prdata = PDATA_W'(cfg.block_end);
      default:  prdata = '0;
    endcase
  end

endmodule

/* hdl/bba_ctrl.sv */
// Request sequencer: range checks, word scan for find, read-modify-write
// for marks and frees, and the output register. Depends on bba_pkg and bba_map_ram.

module bba_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  bba_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               op,
  input  logic [bba_pkg::ID_W-1:0] req_block,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [bba_pkg::ID_W-1:0] found_block,
  output logic                     is_used
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MOD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state, state_next;

  // Request context.
  op_e                op_q;
  logic [WADDR_W-1:0] word_q;
  logic [BIT_W-1:0]   bit_q;

  // Pending result.
  status_e         res_status;
  logic [ID_W-1:0] res_found;
  logic            res_used;

  // One valid bit per map word; an invalid word reads as all free.
  logic [MAP_WORDS-1:0] row_valid;

  // RAM port.
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word_data;

  // Window and request decode.
  logic [ID_W:0]        span;
  logic [NW-1:0]        win_len;
  logic [NW-1:0]        win_last;
  logic [WADDR_W-1:0]   last_word;
  logic [BIT_W-1:0]     last_bit;
  logic [ID_W:0]        offset;
  logic                 in_range;
  logic [IDX_W-1:0]     req_idx;
  logic                 accept;

  // Scan.
  logic [WORD_BITS-1:0] free_bits;
  logic                 hit;
  logic [BIT_W-1:0]     hit_pos;
  logic [ID_W-1:0]      hit_block;
  logic                 out_free;

  bba_map_ram #(
    .DEPTH  (MAP_WORDS),
    .WIDTH  (WORD_BITS),
    .ADDR_W (WADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign word_data = row_valid[word_q] ? ram_rdata : '0;

  // Usable window length: min(block_end - base_block, MAP_BITS), or zero.
  always_comb begin
    span = {1'b0, cfg.block_end} - {1'b0, cfg.base_block};
    if (cfg.base_block >= cfg.block_end) begin
      win_len = '0;
    end else if (span > (ID_W+1)'(MAP_BITS)) begin
      win_len = NW'(MAP_BITS);
    end else begin
      win_len = NW'(span);
    end
    win_last  = win_len - NW'(1);
    last_word = WADDR_W'(win_last >> BIT_W);
    last_bit  = win_last[BIT_W-1:0];
  end

  // Range check for marks, frees and tests.
  always_comb begin
    offset   = {1'b0, req_block} - {1'b0, cfg.base_block};
    in_range = (req_block >= cfg.base_block) && (offset < (ID_W+1)'(win_len));
    req_idx  = IDX_W'(offset);
  end

  // Lowest free bit of the current word inside the window.
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      free_bits[b] = !word_data[b] &&
                     ((word_q != last_word) || (BIT_W'(b) <= last_bit));
    end
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit     = 1'b1;
        hit_pos = BIT_W'(b);
      end
    end
    hit_block = ID_W'(32'(cfg.base_block) + 32'({word_q, hit_pos}));
  end

  // Next state and memory accesses.
  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = word_q;
    ram_we     = 1'b0;
    ram_waddr  = word_q;
    ram_wdata  = word_data;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_e'(op) == OP_FIND) begin
            if (win_len != '0) begin
              ram_re     = 1'b1;
              ram_raddr  = '0;
              state_next = S_SCAN;
            end else begin
              state_next = S_OUT;
            end
          end else if (in_range) begin
            ram_re     = 1'b1;
            ram_raddr  = WADDR_W'(req_idx >> BIT_W);
            state_next = S_MOD;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (hit || (word_q == last_word)) begin
          state_next = S_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = word_q + WADDR_W'(1);
        end
      end
      S_MOD: begin
        ram_wdata = word_data;
        if (op_q == OP_MARK) begin
          ram_we           = 1'b1;
          ram_wdata[bit_q] = 1'b1;
        end else if (op_q == OP_FREE) begin
          ram_we           = 1'b1;
          ram_wdata[bit_q] = 1'b0;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request context and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_q      <= op_e'(op);
          bit_q     <= req_idx[BIT_W-1:0];
          word_q    <= (op_e'(op) == OP_FIND) ? '0 : WADDR_W'(req_idx >> BIT_W);
          res_used  <= 1'b0;
          if (op_e'(op) == OP_FIND) begin
            res_status <= ST_NONE_FREE;
            res_found  <= '0;
          end else begin
            res_status <= in_range ? ST_OK : ST_RANGE;
            res_found  <= req_block;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_status <= ST_OK;
          res_found  <= hit_block;
        end else if (word_q != last_word) begin
          word_q <= word_q + WADDR_W'(1);
        end
      end
      S_MOD: begin
        res_used <= word_data[bit_q];
      end
      S_OUT: begin
        if (out_free) begin
          status      <= res_status;
          found_block <= res_found;
          is_used     <= res_used;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/bitmap_block_allocator_unit.sv */
// Top level of the bitmap first-fit block allocator.
// Depends on bba_pkg, bba_regs, bba_ctrl and (through it) bba_map_ram.

// The block keeps a used/free bitmap of MAP_BITS bits in a 128 x 32 synchronous
// RAM, one item at a time. In-range marks, frees and tests read the word;
// marks and frees then write it back. A find walks the map one word per
// cycle through the RAM read port, from word zero to the first word holding
// a free bit inside the window or to the window's last word. The next item
// is taken the cycle after a result is loaded into the output register. Each
// map word has a valid flag cleared by reset, so the whole map reads as free
// straight after reset with no clearing pass. Configuration lives at byte
// addresses 0 (base_block) and 4 (block_end) and should be written only while
// idle.

module bitmap_block_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::PADDR_W-1:0] paddr,
  input  logic [bba_pkg::PDATA_W-1:0] pwdata,
  output logic [bba_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [bba_pkg::ID_W-1:0]    req_block,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [bba_pkg::ID_W-1:0]    found_block,
  output logic                        is_used
);
  import bba_pkg::*;

  cfg_t cfg;

  // Configuration registers.
  bba_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Request sequencer with the bitmap memory.
  bba_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .req_block   (req_block),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_block (found_block),
    .is_used     (is_used)
  );

endmodule

/* tb/bitmap_block_allocator_unit_test.sv */
// Testbench for the bitmap block allocator: directed and random requests under
// several windows, with a shadow bitmap predicting every result.
// Depends on bba_pkg and bitmap_block_allocator_unit.

module bitmap_block_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 150;

  // Expected contents of one result item.
  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] found;
    logic            used;
  } alloc_result_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           op;
  logic [ID_W-1:0]      req_block;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           status;
  logic [ID_W-1:0]      found_block;
  logic                 is_used;

  // Shadow copy of the bitmap and the window registers.
  logic [MAP_BITS-1:0]  shadow_map;
  logic [ID_W-1:0]      shadow_base;
  logic [ID_W-1:0]      shadow_end;
  alloc_result_t        pending_results[$];

  int unsigned          err_count;
  int unsigned          items_sent;
  int unsigned          results_seen;
  int unsigned          window_count;
  int unsigned          n_find, n_mark, n_free, n_test;
  int unsigned          n_none_free, n_range;
  int unsigned          burst_left;
  bit                   hold_req;

  bitmap_block_allocator_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .req_block  (req_block),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .found_block(found_block),
    .is_used    (is_used)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, pending_results.size());
    $display("FAILURE");
    $finish;
  end

  // Works out the result of one request and applies it to the shadow bitmap.
  function automatic alloc_result_t predict_alloc(op_e req_op, logic [ID_W-1:0] id);
    alloc_result_t r;
    int unsigned   span;
    int unsigned   idx;
    int unsigned   i;
    r.status = ST_OK;
    r.found  = id;
    r.used   = 1'b0;
    span = (shadow_base >= shadow_end) ? 0 : shadow_end - shadow_base;
    if (span > MAP_BITS) span = MAP_BITS;
    if (req_op == OP_FIND) begin
      r.status = ST_NONE_FREE;
      r.found  = '0;
      for (i = 0; i < span; i++) begin
        if (!shadow_map[i]) begin
          r.status = ST_OK;
          r.found  = ID_W'(shadow_base + i);
          break;
        end
      end
    end else if (id < shadow_base || (id - shadow_base) >= span) begin
      r.status = ST_RANGE;
    end else begin
      idx = 32'(id - shadow_base);
      r.used = shadow_map[idx];
      if (req_op == OP_MARK) shadow_map[idx] = 1'b1;
      else if (req_op == OP_FREE) shadow_map[idx] = 1'b0;
    end
    return r;
  endfunction

  // Offers one item and waits for it to be taken; the prediction is queued on acceptance.
  task automatic send_item(input op_e req_op, input logic [ID_W-1:0] id,
                           output alloc_result_t predicted);
    in_valid  <= 1'b1;
    op        <= req_op;
    req_block <= id;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_alloc(req_op, id);
    pending_results.insert(pending_results.size(), predicted);
    items_sent++;
    case (req_op)
      OP_FIND: n_find++;
      OP_MARK: n_mark++;
      OP_FREE: n_free++;
      default: n_test++;
    endcase
  endtask

  // Sender pacing: bursts of back-to-back items separated by random gaps.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every expected result has arrived and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle completing when pready is high, then back to idle.
  task automatic write_reg(input reg_idx_e idx, input logic [ID_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BASE) shadow_base = value;
    else shadow_end = value;
    @(posedge clk);
  endtask

  // Moves the window once the block is idle.
  task automatic set_window(input logic [ID_W-1:0] base, input logic [ID_W-1:0] stop);
    wait_idle();
    write_reg(REG_BASE, base);
    write_reg(REG_END, stop);
    window_count++;
  endtask

  // Picks an id inside the window, biased towards its low end so finds meet used blocks.
  function automatic logic [ID_W-1:0] pick_window_id();
    int unsigned span;
    span = (shadow_base >= shadow_end) ? 0 : shadow_end - shadow_base;
    if (span > MAP_BITS) span = MAP_BITS;
    if (span == 0) return ID_W'($urandom);
    if (span > 256 && $urandom_range(0, 3) != 0) span = 256;
    return ID_W'(shadow_base + $urandom_range(0, span - 1));
  endfunction

  // Receiver stall pattern, with a long hold-off on request.
  initial begin
    int unsigned mode;
    int unsigned span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(30, 250);
      repeat (span) begin
        @(posedge clk);
        if (hold_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  // Result checker: each accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("Unexpected result: status %0d found %0d used %0d",
                   status, found_block, is_used);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status == ST_NONE_FREE) n_none_free++;
        if (exp_r.status == ST_RANGE) n_range++;
        if (status !== exp_r.status || found_block !== exp_r.found ||
            is_used !== exp_r.used) begin
          err_count++;
          if (err_count <= 10)
            $display({"Mismatch on result %0d: expected status %0d found %0d used %0d,",
                      " got status %0d found %0d used %0d"},
                     results_seen, exp_r.status, exp_r.found, exp_r.used,
                     status, found_block, is_used);
        end
      end
    end
  end

  // Requests straight after reset under the default window.
  task automatic test_reset_state();
    alloc_result_t r;
    send_item(OP_FIND, 16'd0,    r);
    send_item(OP_TEST, 16'd0,    r);
    send_item(OP_MARK, 16'd0,    r);
    send_item(OP_MARK, 16'd0,    r);
    send_item(OP_FIND, 16'hFFFF, r);
    send_item(OP_TEST, 16'd4095, r);
    send_item(OP_MARK, 16'd4095, r);
    send_item(OP_TEST, 16'd4096, r);
    send_item(OP_FREE, 16'hFFFF, r);
    send_item(OP_FREE, 16'd0,    r);
    send_item(OP_FREE, 16'd0,    r);
  endtask

  // Empty, inverted, oversized and single-block windows.
  task automatic test_window_edges();
    alloc_result_t r;
    set_window(16'd0, 16'd0);
    send_item(OP_FIND, 16'd0, r);
    send_item(OP_TEST, 16'd0, r);
    set_window(16'hFFFF, 16'hFFFF);
    send_item(OP_FIND, 16'd0, r);
    send_item(OP_MARK, 16'hFFFF, r);
    set_window(16'd300, 16'd20);
    send_item(OP_FIND, 16'd0, r);
    set_window(16'd0, 16'hFFFF);
    send_item(OP_TEST, 16'd4096, r);
    send_item(OP_MARK, 16'd4095, r);
    send_item(OP_FIND, 16'd0, r);
    set_window(16'hF000, 16'hFFFF);
    send_item(OP_MARK, 16'hFFFE, r);
    send_item(OP_TEST, 16'hFFFF, r);
    send_item(OP_TEST, 16'hEFFF, r);
    send_item(OP_FIND, 16'd0, r);
    set_window(16'd5, 16'd6);
    send_item(OP_FIND, 16'd0, r);
    send_item(OP_MARK, 16'd5, r);
    send_item(OP_FIND, 16'd0, r);
  endtask

  // Random traffic inside one window: mostly allocations and frees, some noise.
  task automatic test_random_traffic(input logic [ID_W-1:0] base,
                                     input logic [ID_W-1:0] stop,
                                     input int unsigned count);
    alloc_result_t r;
    int unsigned   start;
    int unsigned   pick;
    set_window(base, stop);
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Allocation: find the lowest free block, then claim it.
        send_item(OP_FIND, ID_W'($urandom), r);
        pace();
        if (r.status == ST_OK) begin
          send_item(OP_MARK, r.found, r);
          pace();
        end
      end else begin
        if (pick < 60) send_item(OP_FREE, pick_window_id(), r);
        else if (pick < 75) send_item(OP_TEST, pick_window_id(), r);
        else if (pick < 85) send_item(OP_MARK, pick_window_id(), r);
        else send_item(op_e'($urandom_range(0, 3)), ID_W'($urandom), r);
        pace();
      end
    end
  endtask

  // The receiver holds off while items keep coming, then the sender waits for the backlog.
  task automatic test_output_hold();
    alloc_result_t r;
    int unsigned   k;
    wait_idle();
    hold_req = 1'b1;
    for (k = 0; k < 12; k++) begin
      if (k % 3 == 0) send_item(OP_FIND, 16'd0, r);
      else send_item(op_e'($urandom_range(1, 3)), pick_window_id(), r);
    end
    wait_idle();
  endtask

  // Main sequence.
  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    op          = OP_FIND;
    req_block   = '0;
    hold_req    = 1'b0;
    shadow_map  = '0;
    shadow_base = BASE_RESET;
    shadow_end  = END_RESET;
    burst_left  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_window_edges();
    test_random_traffic(16'd0,     16'd64,    110);
    test_random_traffic(16'd1000,  16'd1100,  110);
    test_random_traffic(16'hFFC0,  16'hFFFF,  100);
    test_output_hold();
    test_random_traffic(16'd0,     16'd4096,  110);
    test_random_traffic(16'd0,     16'hFFFF,  110);
    test_random_traffic(16'd40000, 16'd41000, 110);

    // Drain and allow for any stray late result.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    err_count += pending_results.size();

    $display("Sent %0d items (%0d find, %0d mark, %0d free, %0d test) over %0d windows.",
             items_sent, n_find, n_mark, n_free, n_test, window_count);
    $display("Checked %0d results, %0d none-free and %0d out-of-range; %0d errors.",
             results_seen, n_none_free, n_range, err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
